@@ rtl/core/rpn_pkg.sv @@
`default_nettype none

package rpn_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;

    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);

    // fixed field widths at the ports
    localparam int OP_W      = 3;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 5;
    localparam int STATUS_W  = 3;
    localparam int M_TDATA_W = 40;

    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DIV_ZERO  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_SATURATED = 3'd4;

    typedef struct packed {
        logic                  start;
        logic [OP_W-1:0]       op;
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic                  done;
        logic                  sat;
        logic [DATA_WIDTH-1:0] value;
    } alu_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/rpn_stack_mem.sv @@
`default_nettype none

module rpn_stack_mem (
    input  wire logic                           aclk,
    input  wire logic                           we,
    input  wire logic [rpn_pkg::ADDR_W-1:0]     waddr,
    input  wire logic [rpn_pkg::DATA_WIDTH-1:0] wdata,
    input  wire logic [rpn_pkg::ADDR_W-1:0]     raddr,
    output logic      [rpn_pkg::DATA_WIDTH-1:0] rdata
);
    import rpn_pkg::*;

    logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/rpn_alu.sv @@
`default_nettype none

module rpn_alu (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rpn_pkg::alu_req_t req,
    output rpn_pkg::alu_rsp_t      rsp
);
    import rpn_pkg::*;

    localparam int MW    = DATA_WIDTH;
    localparam int LW    = DATA_WIDTH + FRAC_BITS;
    localparam int CNT_W = $clog2(LW + 1);

    localparam logic [MW-1:0] MAX_POS = {1'b0, {(MW-1){1'b1}}};
    localparam logic [MW-1:0] MIN_NEG = {1'b1, {(MW-1){1'b0}}};

    logic             busy_reg, busy_next;
    logic             fin_reg, fin_next;
    logic             mul_reg, mul_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MW:0]      hi_reg, hi_next;
    logic [LW-1:0]    lo_reg, lo_next;
    logic [MW-1:0]    mc_reg, mc_next;
    logic             done_reg, done_next;
    logic             sat_reg, sat_next;
    logic [MW-1:0]    val_reg, val_next;

    logic [MW-1:0]   mag_a, mag_b;
    logic [MW:0]     x, y;
    logic [MW+1:0]   s;
    logic            ge;
    logic [MW:0]     as_sum;
    logic            as_ovf;
    logic [2*MW-1:0] prod;
    logic [MW-1:0]   mag, limit, clamp;
    logic            over, sat;

    assign mag_a = req.a[MW-1] ? (~req.a + MW'(1)) : req.a;
    assign mag_b = req.b[MW-1] ? (~req.b + MW'(1)) : req.b;

    // shared adder: accumulate for multiply, trial subtract for divide
    assign x  = mul_reg ? hi_reg : {hi_reg[MW-1:0], lo_reg[LW-1]};
    assign y  = mul_reg ? (lo_reg[0] ? {1'b0, mc_reg} : '0) : ~{1'b0, mc_reg};
    assign s  = {1'b0, x} + {1'b0, y} + (MW+2)'(!mul_reg);
    assign ge = s[MW+1];

    always_comb begin
        if (req.op == OP_SUB) begin
            as_sum = {req.a[MW-1], req.a} - {req.b[MW-1], req.b};
        end else begin
            as_sum = {req.a[MW-1], req.a} + {req.b[MW-1], req.b};
        end
        as_ovf = as_sum[MW] != as_sum[MW-1];
    end

    // final scaling and clamp of the magnitude
    assign prod = {hi_reg[MW-1:0], lo_reg[LW-1 -: MW]};
    always_comb begin
        if (mul_reg) begin
            over = (prod >> (FRAC_BITS + MW)) != '0;
            mag  = prod[FRAC_BITS +: MW];
        end else begin
            over = (lo_reg >> MW) != '0;
            mag  = lo_reg[MW-1:0];
        end
        limit = neg_reg ? MIN_NEG : MAX_POS;
        sat   = over || (mag > limit);
        clamp = sat ? limit : mag;
    end

    always_comb begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        mul_next  = mul_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        mc_next   = mc_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        val_next  = val_reg;
        if (req.start) begin
            neg_next = req.a[MW-1] ^ req.b[MW-1];
            hi_next  = '0;
            case (req.op) inside
                OP_ADD, OP_SUB: begin
                    done_next = 1'b1;
                    sat_next  = as_ovf;
                    val_next  = as_ovf ? (as_sum[MW] ? MIN_NEG : MAX_POS) : as_sum[MW-1:0];
                end
                OP_MUL: begin
                    busy_next = 1'b1;
                    mul_next  = 1'b1;
                    cnt_next  = CNT_W'(MW);
                    lo_next   = LW'(mag_b);
                    mc_next   = mag_a;
                end
                default: begin
                    busy_next = 1'b1;
                    mul_next  = 1'b0;
                    cnt_next  = CNT_W'(LW);
                    lo_next   = LW'(mag_a) << FRAC_BITS;
                    mc_next   = mag_b;
                end
            endcase
        end else if (busy_reg) begin
            if (mul_reg) begin
                hi_next = s[MW+1:1];
                lo_next = {s[0], lo_reg[LW-1:1]};
            end else begin
                hi_next = ge ? s[MW:0] : x;
                lo_next = {lo_reg[LW-2:0], ge};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end else if (fin_reg) begin
            done_next = 1'b1;
            sat_next  = sat;
            val_next  = neg_reg ? (~clamp + MW'(1)) : clamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
        mul_reg <= mul_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        mc_reg  <= mc_next;
        sat_reg <= sat_next;
        val_reg <= val_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.sat   = sat_reg;
    assign rsp.value = val_reg;

endmodule

`default_nettype wire

@@ rtl/core/rpn_stack_evaluator_unit.sv @@
`default_nettype none

// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   tuser: op; tdata: operand
// m_        out  m_tvalid/m_tready   tdata: top_value, stack_count, status
//
// A push or a rejected request passes S_READ and then S_FIN after accept.
// Add, subtract, multiply and divide pass S_READ, S_WAIT and S_FIN; in
// S_WAIT, multiply and divide wait on the shared add/subtract unit, which
// retires one product or quotient bit per cycle.
// s_tready is high only while no request is in work; a result waiting on
// m_tready holds the next request at its last step, not at accept.
// Reset clears the entry count and the handshake state; stack entries
// are not cleared and only entries below the count are read.
module rpn_stack_evaluator_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [rpn_pkg::VALUE_W-1:0]   s_tdata,  // [31:0] operand
    input  wire logic [rpn_pkg::OP_W-1:0]      s_tuser,  // [2:0] op
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [31:0] top_value, [36:32] stack_count, [39:37] status
    output logic      [rpn_pkg::M_TDATA_W-1:0] m_tdata
);
    import rpn_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam logic [LEVEL_W-1:0] FULL = LEVEL_W'(STACK_DEPTH);

    logic [1:0]            state_reg, state_next;
    logic [LEVEL_W-1:0]    level_reg, level_next;
    logic [DATA_WIDTH-1:0] top_reg, top_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [VALUE_W-1:0]    operand_reg, operand_next;
    logic                  out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]  out_data_reg, out_data_next;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;
    logic [LEVEL_W-1:0]    level_m2;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    rpn_stack_mem u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rpn_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

    assign level_m2  = level_reg - LEVEL_W'(2);
    // entry below the top; captured at the accept edge
    assign mem_raddr = level_m2[ADDR_W-1:0];

    always_comb begin
        state_next     = state_reg;
        level_next     = level_reg;
        top_next       = top_reg;
        status_next    = status_reg;
        op_next        = op_reg;
        operand_next   = operand_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = level_reg[ADDR_W-1:0];
        mem_wdata      = top_reg;
        alu_req.start  = 1'b0;
        alu_req.op     = op_reg;
        alu_req.a      = mem_rdata;
        alu_req.b      = top_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next      = s_tuser;
                    operand_next = s_tdata;
                    state_next   = S_READ;
                end
            end
            S_READ: begin
                status_next = STAT_OK;
                state_next  = S_FIN;
                if (op_reg == OP_PUSH) begin
                    if (level_reg >= FULL) begin
                        status_next = STAT_OVERFLOW;
                    end else begin
                        mem_we     = 1'b1;
                        mem_wdata  = DATA_WIDTH'($signed(operand_reg));
                        top_next   = mem_wdata;
                        level_next = level_reg + LEVEL_W'(1);
                    end
                end else if (op_reg <= OP_DIV) begin
                    if (level_reg < LEVEL_W'(2)) begin
                        status_next = STAT_UNDERFLOW;
                    end else if (op_reg == OP_DIV && top_reg == '0) begin
                        status_next = STAT_DIV_ZERO;
                    end else begin
                        alu_req.start = 1'b1;
                        state_next    = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (alu_rsp.done) begin
                    mem_we      = 1'b1;
                    mem_waddr   = level_m2[ADDR_W-1:0];
                    mem_wdata   = alu_rsp.value;
                    top_next    = alu_rsp.value;
                    level_next  = level_reg - LEVEL_W'(1);
                    status_next = alu_rsp.sat ? STAT_SATURATED : STAT_OK;
                    state_next  = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {status_reg, COUNT_W'(level_reg), VALUE_W'(top_reg)};
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            level_reg     <= '0;
            top_reg       <= '0;
            status_reg    <= STAT_OK;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            top_reg       <= top_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
        op_reg       <= op_next;
        operand_reg  <= operand_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= FULL)
        else $error("stack count beyond depth");

    a_alu_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_rsp.done |-> state_reg == S_WAIT)
        else $error("arithmetic result outside wait state");

    a_level_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_READ && state_reg != S_WAIT) |=> $stable(level_reg))
        else $error("stack count changed outside an update step");

    a_result_after_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == S_FIN)
        else $error("result raised without a finished request");
`endif

endmodule

`default_nettype wire
